// ----- hw/rtl/tss_pkg.sv -----
// Shared types and constants for the touch slider segmenter.
// Holds the slot setup layout, sequencer states and divider sizing.
// No dependencies; imported by tss_div and touch_slider_segmenter.
`default_nettype none

package tss_pkg;

  localparam int REG_COUNT = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SETUP_W   = 34;
  localparam int POS_W     = 16;
  localparam int SUB_IDX_W = 2;

  localparam logic [POS_W-1:0] FULL_SCALE = 16'hFFFF;
  localparam logic [POS_W-1:0] HALF_SCALE = 16'(16'hFFFF / 2);

  // One quotient bit per divider step
  localparam int DIV_STEPS = POS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic             enabled;
    logic             reversed;
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] lo;
  } sub_setup_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } tss_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tss_div.sv -----
// Restoring divider: (diff * 0xFFFF) / span, one quotient bit per cycle.
// Requires diff <= span and span != 0 so the quotient fits 16 bits.
// Depends on tss_pkg.
`default_nettype none

module tss_div
  import tss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] diff,
  input  wire logic [POS_W-1:0] span,
  output logic                  done,
  output logic [POS_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]     dvd_r, dvd_nxt;

  logic [2*POS_W-1:0]   num;
  logic [POS_W:0]       shifted;
  logic [POS_W:0]       trial;

  // diff * 0xFFFF = (diff << 16) - diff
  assign num     = {diff, {POS_W{1'b0}}} - {{POS_W{1'b0}}, diff};
  assign shifted = {rem_r, dvd_r[POS_W-1]};
  assign trial   = shifted - {1'b0, span};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_nxt  = num[2*POS_W-1:POS_W];
      dvd_nxt  = num[POS_W-1:0];
    end else if (busy_r) begin
      if (!trial[POS_W]) begin
        rem_nxt = trial[POS_W-1:0];
        dvd_nxt = {dvd_r[POS_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[POS_W-1:0];
        dvd_nxt = {dvd_r[POS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/touch_slider_segmenter.sv -----
// Top level of the touch slider segmenter: slot setup registers, held state,
// query sequencer and output register. Depends on tss_pkg and tss_div.
`default_nettype none

// Channel   Direction  Ports                                      Handshake
// -------   ---------  -----------------------------------------  ------------
// in        input      in_sub_index, in_raw_touched,              valid / stall
//                      in_raw_position
// out       output     out_sub_touched, out_sub_value             valid / stall
// cfg       input      cfg_index, cfg_data                        cfg_we only
//
// One transaction at a time. An accepted query is decoded in ST_EVAL;
// an in-bounds touch on a non-degenerate slot then runs the shared restoring
// divider, waits in ST_DIV for its done strobe and passes through a finish
// step, ST_FIN, that writes the output register, after which the next query
// is taken. A query decided in decode writes the output register from
// ST_EVAL; a zero-width slot skips the divider and goes straight to ST_FIN.
// Reset (synchronous, active low) clears the setup registers, held flags
// and last values. in_stall is high while a query is in flight; out_stall
// holds the output register, and the sequencer waits in its last step until
// the register is free.

module touch_slider_segmenter
  import tss_pkg::*;
#(
  parameter int SUB_COUNT = 4
)
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SETUP_W-1:0]   cfg_data,
  // queries
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SUB_IDX_W-1:0] in_sub_index,
  input  wire logic                 in_raw_touched,
  input  wire logic [POS_W-1:0]     in_raw_position,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_sub_touched,
  output logic [POS_W-1:0]          out_sub_value
);

  localparam int IDX_W = (SUB_COUNT > 1) ? $clog2(SUB_COUNT) : 1;

  // slot setup registers
  logic [SETUP_W-1:0] setup_r [REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        setup_r[i] <= '0;
      end
    end else if (cfg_we) begin
      setup_r[cfg_index] <= cfg_data;
    end
  end

  // sequencer and per-slot state
  tss_state_t state_r, state_nxt;

  logic                 held_r [SUB_COUNT];
  logic                 held_nxt [SUB_COUNT];
  logic [POS_W-1:0]     last_r [SUB_COUNT];
  logic [POS_W-1:0]     last_nxt [SUB_COUNT];

  logic [SUB_IDX_W-1:0] idx_r, idx_nxt;
  logic                 touch_r, touch_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 zero_q_r, zero_q_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_touched_r, out_touched_nxt;
  logic [POS_W-1:0]     out_value_r, out_value_nxt;

  // decode of the captured query
  sub_setup_t           cur;
  logic [IDX_W-1:0]     slot;
  logic                 idx_ok;
  logic                 in_bounds;
  logic                 other_held;
  logic [POS_W-1:0]     span;
  logic [POS_W-1:0]     diff;
  logic                 out_free;
  logic [POS_W-1:0]     scaled;
  logic [POS_W-1:0]     final_val;

  logic                 div_start;
  logic                 div_done;
  logic [POS_W-1:0]     div_q;

  assign cur       = sub_setup_t'(setup_r[idx_r]);
  assign slot      = IDX_W'(idx_r);
  assign idx_ok    = (int'(idx_r) < SUB_COUNT);
  assign in_bounds = (pos_r >= cur.lo) && (pos_r <= cur.hi);
  assign span      = cur.hi - cur.lo;
  assign diff      = pos_r - cur.lo;
  assign out_free  = !out_valid_r || !out_stall;
  assign scaled    = zero_q_r ? '0 : div_q;
  assign final_val = cur.reversed ? (FULL_SCALE - scaled) : scaled;

  // any slot other than the queried one still held blocks a new touch
  always_comb begin
    other_held = 1'b0;
    for (int i = 0; i < SUB_COUNT; i++) begin
      if (held_r[i] && (i != int'(idx_r))) begin
        other_held = 1'b1;
      end
    end
  end

  tss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .diff     (diff),
    .span     (span),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    last_nxt        = last_r;
    idx_nxt         = idx_r;
    touch_nxt       = touch_r;
    pos_nxt         = pos_r;
    zero_q_nxt      = zero_q_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_touched_nxt = out_touched_r;
    out_value_nxt   = out_value_r;
    div_start       = 1'b0;
    in_stall        = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        // capture the query
        if (in_valid) begin
          idx_nxt   = in_sub_index;
          touch_nxt = in_raw_touched;
          pos_nxt   = in_raw_position;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (!idx_ok) begin
          // slot beyond the configured count: not touched, no state change
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_touched_nxt = 1'b0;
            out_value_nxt   = '0;
            state_nxt       = ST_IDLE;
          end
        end else if (cur.enabled && touch_r && in_bounds) begin
          if (other_held) begin
            // another sub-slider owns the touch: report idle, keep state
            if (out_free) begin
              out_valid_nxt   = 1'b1;
              out_touched_nxt = 1'b0;
              out_value_nxt   = '0;
              state_nxt       = ST_IDLE;
            end
          end else if (span == '0) begin
            // degenerate bounds scale to zero, skip the divider
            zero_q_nxt = 1'b1;
            state_nxt  = ST_FIN;
          end else begin
            zero_q_nxt = 1'b0;
            div_start  = 1'b1;
            state_nxt  = ST_DIV;
          end
        end else if (cur.enabled && touch_r && held_r[slot]) begin
          // slid off the end while held: pin to the nearer end
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_touched_nxt = 1'b1;
            out_value_nxt   = (last_r[slot] < HALF_SCALE) ? '0 : FULL_SCALE;
            state_nxt       = ST_IDLE;
          end
        end else begin
          // released, disabled or outside while not held: drop the hold
          if (out_free) begin
            held_nxt[slot]  = 1'b0;
            out_valid_nxt   = 1'b1;
            out_touched_nxt = 1'b0;
            out_value_nxt   = '0;
            state_nxt       = ST_IDLE;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        // store the scaled value, mark the slot held, report it
        if (out_free) begin
          last_nxt[slot]  = final_val;
          held_nxt[slot]  = 1'b1;
          out_valid_nxt   = 1'b1;
          out_touched_nxt = 1'b1;
          out_value_nxt   = final_val;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SUB_COUNT; i++) begin
        held_r[i] <= 1'b0;
        last_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    touch_r       <= touch_nxt;
    pos_r         <= pos_nxt;
    zero_q_r      <= zero_q_nxt;
    out_touched_r <= out_touched_nxt;
    out_value_r   <= out_value_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_sub_touched = out_touched_r;
  assign out_sub_value   = out_value_r;

endmodule

`default_nettype wire
